@@ sv/battery_level_gauge_defines.svh @@
// Assertion macros shared by the battery level gauge RTL.
`ifndef BATTERY_LEVEL_GAUGE_DEFINES_SVH
`define BATTERY_LEVEL_GAUGE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define BLG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define BLG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BLG_ASSERT(lbl, prop, msg)
`define BLG_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ sv/blg_pkg.sv @@
// Package with widths, register defaults and shared types of the battery level gauge.
`timescale 1ns / 1ps
`default_nettype none

package blg_pkg;

  localparam int ADC_BITS_DEF = 12;

  localparam int CODE_W  = 12;
  localparam int LEVEL_W = 7;
  localparam int TICK_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CODE_W-1:0] FULL_THRESHOLD_RST  = 12'd1548;
  localparam logic [CODE_W-1:0] UPPER_KNEE_RST      = 12'd1468;
  localparam logic [CODE_W-1:0] MID_KNEE_RST        = 12'd1342;
  localparam logic [CODE_W-1:0] MID_OFFSET_RST      = 12'd1330;
  localparam logic [CODE_W-1:0] LOW_KNEE_RST        = 12'd1191;
  localparam logic [TICK_W-1:0] STEP_TICKS_RST      = 16'd1000;
  localparam logic [TICK_W-1:0] FULL_HOLD_TICKS_RST = 16'd3000;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL      = 7'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX_SHOWN = 7'd99;
  localparam logic [LEVEL_W-1:0] LEVEL_UPPER_CAP = 7'd98;
  localparam logic [LEVEL_W-1:0] LEVEL_UPPER_BASE = 7'd80;
  localparam logic [LEVEL_W-1:0] LEVEL_MID_BASE  = 7'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_THRESHOLD  = 3'd0,
    REG_UPPER_KNEE      = 3'd1,
    REG_MID_KNEE        = 3'd2,
    REG_MID_OFFSET      = 3'd3,
    REG_LOW_KNEE        = 3'd4,
    REG_STEP_TICKS      = 3'd5,
    REG_FULL_HOLD_TICKS = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CODE_W-1:0] full_threshold;
    logic [CODE_W-1:0] upper_knee;
    logic [CODE_W-1:0] mid_knee;
    logic [CODE_W-1:0] mid_offset;
    logic [CODE_W-1:0] low_knee;
    logic [TICK_W-1:0] step_ticks;
    logic [TICK_W-1:0] full_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TICK_W-1:0]  full_timer_nxt;
  } curve_res_t;

endpackage

`default_nettype wire

@@ sv/blg_if.sv @@
// Stream interfaces for the gauge input sample word and the result word.
`timescale 1ns / 1ps
`default_nettype none

interface blg_in_if;
  import blg_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] voltage_code;
  logic              charging;
  logic              resync;

  modport source (output valid, output voltage_code, output charging, output resync,
                  input ready);
  modport sink   (input valid, input voltage_code, input charging, input resync,
                  output ready);
endinterface

interface blg_out_if;
  import blg_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] shown_level;

  modport source (output valid, output level, output shown_level, input ready);
  modport sink   (input valid, input level, input shown_level, output ready);
endinterface

`default_nettype wire

@@ sv/blg_curve.sv @@
// Piecewise-linear voltage-to-level curve with the full-segment hold counter.
`timescale 1ns / 1ps
`default_nettype none

module blg_curve #(
  parameter int ADC_BITS = blg_pkg::ADC_BITS_DEF
) (
  input  wire logic [blg_pkg::CODE_W-1:0] voltage_code,
  input  wire blg_pkg::cfg_t              cfg,
  input  wire logic [blg_pkg::TICK_W-1:0] full_timer,
  output blg_pkg::curve_res_t             res
);
  import blg_pkg::*;

  localparam logic [CODE_W-1:0] CodeMask =
    (ADC_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((1 << ADC_BITS) - 1);

  // floor(x / 15) equals (x * RecipFifteen) >> 19 for every x below 2**16.
  localparam logic [15:0] RecipFifteen = 16'd34953;

  logic [CODE_W-1:0] code;
  logic [TICK_W:0]   full_inc;
  logic [CODE_W-1:0] up_diff;
  logic [CODE_W-1:0] mid_diff;
  logic [CODE_W-1:0] low_diff;
  logic [27:0]       low_prod;
  logic [8:0]        low_quot;

  assign code     = voltage_code & CodeMask;
  assign full_inc = {1'b0, full_timer} + (TICK_W+1)'(1);
  assign up_diff  = code - cfg.upper_knee;
  assign mid_diff = (code > cfg.mid_offset) ? code - cfg.mid_offset : '0;
  assign low_diff = code - cfg.low_knee;
  assign low_prod = 28'(low_diff) * 28'(RecipFifteen);
  assign low_quot = low_prod[27:19];

  always_comb begin
    res.full_timer_nxt = full_timer;
    res.level          = '0;
    if (code > cfg.full_threshold) begin
      if (full_inc > {1'b0, cfg.full_hold_ticks}) begin
        res.full_timer_nxt = cfg.full_hold_ticks;
        res.level          = LEVEL_FULL;
      end else begin
        res.full_timer_nxt = full_inc[TICK_W-1:0];
        res.level          = LEVEL_MAX_SHOWN;
      end
    end else if (code > cfg.upper_knee) begin
      res.full_timer_nxt = '0;
      // Past 99 the upper segment reports 98 rather than wrapping into full.
      if (up_diff[CODE_W-1:2] > 10'd19) begin
        res.level = LEVEL_UPPER_CAP;
      end else begin
        res.level = LEVEL_UPPER_BASE + LEVEL_W'(up_diff[CODE_W-1:2]);
      end
    end else if (code > cfg.mid_knee) begin
      if (mid_diff[CODE_W-1:1] > 11'd90) begin
        res.level = LEVEL_FULL;
      end else begin
        res.level = LEVEL_MID_BASE + LEVEL_W'(mid_diff[CODE_W-1:1]);
      end
    end else if (code > cfg.low_knee) begin
      if (low_quot > 9'd100) begin
        res.level = LEVEL_FULL;
      end else begin
        res.level = LEVEL_W'(low_quot);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/battery_level_gauge.sv @@
// Top level of the battery level gauge: registers, display smoothing and handshake.
`timescale 1ns / 1ps
`default_nettype none
`include "battery_level_gauge_defines.svh"

// Battery level gauge. Each input word (voltage code, charging, resync) is
// captured in an input register, mapped to a 0..100 level on the configured
// curve and folded into the smoothed display level, and the pair lands in an
// output register. A new word is taken every clock cycle while the input
// register is empty or its word moves on; the output register takes that
// word when it is empty or its result is being taken, and drives the result
// valid. The bottom segment's divide-by-fifteen multiply followed by the
// display compare chain sets the clock period. Configuration writes take
// effect on the next edge and are meant to happen while no word is in flight.
module battery_level_gauge #(
  parameter int ADC_BITS = blg_pkg::ADC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  blg_in_if.sink                              in_s,
  blg_out_if.source                           out_m,
  input  wire logic                           cfg_we,
  input  wire logic [blg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [blg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import blg_pkg::*;

  cfg_t cfg_r;

  logic              s1_v_r;
  logic [CODE_W-1:0] s1_code_r;
  logic              s1_charging_r;
  logic              s1_resync_r;

  logic               out_v_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [LEVEL_W-1:0] out_shown_r;

  logic [TICK_W-1:0]  full_timer_r;
  logic [TICK_W-1:0]  fall_timer_r, fall_timer_nxt;
  logic [TICK_W-1:0]  rise_timer_r, rise_timer_nxt;
  logic [LEVEL_W-1:0] disp_r, disp_nxt;

  logic       advance;
  curve_res_t curve;

  assign advance    = s1_v_r && (!out_v_r || out_m.ready);
  assign in_s.ready = !s1_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_threshold  <= FULL_THRESHOLD_RST;
      cfg_r.upper_knee      <= UPPER_KNEE_RST;
      cfg_r.mid_knee        <= MID_KNEE_RST;
      cfg_r.mid_offset      <= MID_OFFSET_RST;
      cfg_r.low_knee        <= LOW_KNEE_RST;
      cfg_r.step_ticks      <= STEP_TICKS_RST;
      cfg_r.full_hold_ticks <= FULL_HOLD_TICKS_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FULL_THRESHOLD:  cfg_r.full_threshold  <= cfg_wdata[CODE_W-1:0];
        REG_UPPER_KNEE:      cfg_r.upper_knee      <= cfg_wdata[CODE_W-1:0];
        REG_MID_KNEE:        cfg_r.mid_knee        <= cfg_wdata[CODE_W-1:0];
        REG_MID_OFFSET:      cfg_r.mid_offset      <= cfg_wdata[CODE_W-1:0];
        REG_LOW_KNEE:        cfg_r.low_knee        <= cfg_wdata[CODE_W-1:0];
        REG_STEP_TICKS:      cfg_r.step_ticks      <= cfg_wdata[TICK_W-1:0];
        REG_FULL_HOLD_TICKS: cfg_r.full_hold_ticks <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  blg_curve #(.ADC_BITS(ADC_BITS)) u_curve (
    .voltage_code (s1_code_r),
    .cfg          (cfg_r),
    .full_timer   (full_timer_r),
    .res          (curve)
  );

  // Display smoothing: reload when empty or on resync, then at most one step down and one step up.
  always_comb begin
    logic [LEVEL_W-1:0] disp_ld;
    logic [LEVEL_W-1:0] disp_fall;
    logic [TICK_W:0]    fall_inc;
    logic [TICK_W:0]    rise_inc;
    disp_ld  = s1_resync_r ? '0 : disp_r;
    if (disp_ld == '0) begin
      disp_ld = curve.level;
    end
    fall_inc = {1'b0, fall_timer_r} + (TICK_W+1)'(1);
    rise_inc = {1'b0, rise_timer_r} + (TICK_W+1)'(1);

    disp_fall      = disp_ld;
    fall_timer_nxt = fall_timer_r;
    if (!s1_charging_r) begin
      if (disp_ld > curve.level) begin
        if (fall_inc > {1'b0, cfg_r.step_ticks}) begin
          fall_timer_nxt = '0;
          disp_fall      = (disp_ld == LEVEL_W'(1)) ? disp_ld : disp_ld - LEVEL_W'(1);
        end else begin
          fall_timer_nxt = fall_inc[TICK_W-1:0];
        end
      end else begin
        fall_timer_nxt = '0;
      end
    end

    disp_nxt       = disp_fall;
    rise_timer_nxt = '0;
    if (disp_fall < curve.level) begin
      if (rise_inc > {1'b0, cfg_r.step_ticks}) begin
        disp_nxt = (disp_fall >= LEVEL_MAX_SHOWN) ? LEVEL_MAX_SHOWN
                                                  : disp_fall + LEVEL_W'(1);
      end else begin
        rise_timer_nxt = rise_inc[TICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      full_timer_r <= '0;
      fall_timer_r <= '0;
      rise_timer_r <= '0;
      disp_r       <= '0;
    end else begin
      if (in_s.ready) begin
        s1_v_r <= in_s.valid;
      end
      if (advance) begin
        out_v_r      <= 1'b1;
        full_timer_r <= curve.full_timer_nxt;
        fall_timer_r <= fall_timer_nxt;
        rise_timer_r <= rise_timer_nxt;
        disp_r       <= disp_nxt;
      end else if (out_m.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      s1_code_r     <= in_s.voltage_code;
      s1_charging_r <= in_s.charging;
      s1_resync_r   <= in_s.resync;
    end
    if (advance) begin
      out_level_r <= curve.level;
      out_shown_r <= disp_nxt;
    end
  end

  assign out_m.valid       = out_v_r;
  assign out_m.level       = out_level_r;
  assign out_m.shown_level = out_shown_r;

  `BLG_ASSERT_RST(a_reset_empty, !rst_n |=> (!s1_v_r && !out_v_r), "pipeline not empty after reset")
  `BLG_ASSERT(a_no_bubble, (s1_v_r && !out_v_r) |-> advance, "held word not moved to empty output")
  `BLG_ASSERT(a_result_follows, advance |=> out_v_r, "result register not loaded after advance")
  `BLG_ASSERT(a_display_one_step, (advance && !s1_resync_r && disp_r != '0) |=>
    ({1'b0, disp_r} <= {1'b0, $past(disp_r)} + 8'd1 &&
     {1'b0, disp_r} + 8'd1 >= {1'b0, $past(disp_r)}), "display moved by more than one")

endmodule

`default_nettype wire

@@ tb/battery_level_gauge_checker.sv @@
// Scoreboard for the battery level gauge: mirrors the gauge state and checks every result word.
`timescale 1ns / 1ps

module battery_level_gauge_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  blg_in_if                              in_mon,
  blg_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [blg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             words_pending
);
  import blg_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] shown_level;
  } gauge_word_t;

  cfg_t        cfg;
  int unsigned full_hold_cnt;
  int unsigned shown;
  int unsigned fall_cnt;
  int unsigned rise_cnt;
  int          err_cnt;
  gauge_word_t level_q[$];

  initial begin
    err_cnt = 0;
  end

  // Advances the mirrored gauge by one sample and returns the word it should emit.
  function automatic gauge_word_t gauge_tick(input logic [CODE_W-1:0] sample,
                                             input logic on_charger, input logic reload);
    int unsigned code;
    int unsigned lvl;
    gauge_word_t w;
    code = sample;
    if (code > cfg.full_threshold) begin
      lvl = LEVEL_MAX_SHOWN;
      if (full_hold_cnt + 1 > cfg.full_hold_ticks) begin
        full_hold_cnt = cfg.full_hold_ticks;
        lvl = LEVEL_FULL;
      end else begin
        full_hold_cnt = full_hold_cnt + 1;
      end
    end else if (code > cfg.upper_knee) begin
      // Only this segment restarts the full hold count.
      full_hold_cnt = 0;
      lvl = (code - cfg.upper_knee) / 4 + LEVEL_UPPER_BASE;
      if (lvl > LEVEL_MAX_SHOWN) lvl = LEVEL_UPPER_CAP;
    end else if (code > cfg.mid_knee) begin
      lvl = ((code > cfg.mid_offset) ? (code - cfg.mid_offset) / 2 : 0) + LEVEL_MID_BASE;
      if (lvl > LEVEL_FULL) lvl = LEVEL_FULL;
    end else if (code > cfg.low_knee) begin
      lvl = (code - cfg.low_knee) / 15;
      if (lvl > LEVEL_FULL) lvl = LEVEL_FULL;
    end else begin
      lvl = 0;
    end

    if (reload) shown = 0;
    if (shown == 0) shown = lvl;

    // The fall count freezes while the charger is connected.
    if (!on_charger) begin
      if (shown > lvl && shown > 0) begin
        fall_cnt = fall_cnt + 1;
        if (fall_cnt > cfg.step_ticks) begin
          fall_cnt = 0;
          shown = shown - 1;
          if (shown == 0) shown = 1;
        end
      end else begin
        fall_cnt = 0;
      end
    end

    if (shown < lvl) begin
      rise_cnt = rise_cnt + 1;
      if (rise_cnt > cfg.step_ticks) begin
        rise_cnt = 0;
        shown = shown + 1;
        if (shown > LEVEL_MAX_SHOWN) shown = LEVEL_MAX_SHOWN;
      end
    end else begin
      rise_cnt = 0;
    end

    full_hold_cnt = full_hold_cnt & 32'hFFFF;
    fall_cnt = fall_cnt & 32'hFFFF;
    rise_cnt = rise_cnt & 32'hFFFF;
    shown = shown & 32'h7F;

    w.level = lvl[LEVEL_W-1:0];
    w.shown_level = shown[LEVEL_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin : scoreboard
    gauge_word_t want;
    if (!rst_n) begin
      cfg.full_threshold = FULL_THRESHOLD_RST;
      cfg.upper_knee = UPPER_KNEE_RST;
      cfg.mid_knee = MID_KNEE_RST;
      cfg.mid_offset = MID_OFFSET_RST;
      cfg.low_knee = LOW_KNEE_RST;
      cfg.step_ticks = STEP_TICKS_RST;
      cfg.full_hold_ticks = FULL_HOLD_TICKS_RST;
      full_hold_cnt = 0;
      shown = 0;
      fall_cnt = 0;
      rise_cnt = 0;
      level_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FULL_THRESHOLD:  cfg.full_threshold = cfg_wdata[CODE_W-1:0];
          REG_UPPER_KNEE:      cfg.upper_knee = cfg_wdata[CODE_W-1:0];
          REG_MID_KNEE:        cfg.mid_knee = cfg_wdata[CODE_W-1:0];
          REG_MID_OFFSET:      cfg.mid_offset = cfg_wdata[CODE_W-1:0];
          REG_LOW_KNEE:        cfg.low_knee = cfg_wdata[CODE_W-1:0];
          REG_STEP_TICKS:      cfg.step_ticks = cfg_wdata[TICK_W-1:0];
          REG_FULL_HOLD_TICKS: cfg.full_hold_ticks = cfg_wdata[TICK_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        level_q.push_back(gauge_tick(in_mon.voltage_code, in_mon.charging, in_mon.resync));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (level_q.size() == 0) begin
          $display("%0t: unexpected result word, level %0d shown_level %0d",
                   $time, out_mon.level, out_mon.shown_level);
          err_cnt++;
        end else begin
          want = level_q.pop_front();
          if (out_mon.level !== want.level) begin
            $display("%0t: level mismatch, expected %0d actual %0d",
                     $time, want.level, out_mon.level);
            err_cnt++;
          end
          if (out_mon.shown_level !== want.shown_level) begin
            $display("%0t: shown_level mismatch, expected %0d actual %0d",
                     $time, want.shown_level, out_mon.shown_level);
            err_cnt++;
          end
        end
      end
    end
    mismatches <= err_cnt;
    words_pending <= level_q.size();
  end

endmodule

@@ tb/battery_level_gauge_tb.sv @@
// Top of the battery level gauge testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module battery_level_gauge_tb;
  import blg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 3'd7;
  localparam int LONG_HOLD_CYCLES = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    words_pending;

  bit   long_hold_req;
  int   burst_left;
  int   gap_max;
  cfg_t cur_cfg;

  blg_in_if  in_if ();
  blg_out_if out_if ();

  battery_level_gauge DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_if),
    .out_m     (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  battery_level_gauge_checker scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: runs of full speed, random and periodic stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    int run_left;
    int rx_mode;
    int rx_tick;
    hold_left = 0;
    run_left = 0;
    rx_mode = 0;
    rx_tick = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          run_left = $urandom_range(20, 200);
        end
        run_left--;
        case (rx_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 99) < 70);
          2: out_if.ready <= ($urandom_range(0, 99) < 25);
          default: out_if.ready <= (rx_tick % 3 != 0);
        endcase
      end
    end
  end

  function automatic logic [CODE_W-1:0] clamp_code(input int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'd4095;
    return v[CODE_W-1:0];
  endfunction

  task automatic send_word(input logic [CODE_W-1:0] code, input logic chg, input logic rs);
    in_if.valid <= 1'b1;
    in_if.voltage_code <= code;
    in_if.charging <= chg;
    in_if.resync <= rs;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Sender works in bursts; between bursts valid may drop for a random gap.
  task automatic offer(input logic [CODE_W-1:0] code, input logic chg, input logic rs);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    send_word(code, chg, rs);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_gauge(input logic [CODE_W-1:0] ft, input logic [CODE_W-1:0] uk,
                               input logic [CODE_W-1:0] mk, input logic [CODE_W-1:0] mo,
                               input logic [CODE_W-1:0] lk, input logic [TICK_W-1:0] st,
                               input logic [TICK_W-1:0] fh);
    write_reg(REG_FULL_THRESHOLD, {4'd0, ft});
    write_reg(REG_UPPER_KNEE, {4'd0, uk});
    write_reg(REG_MID_KNEE, {4'd0, mk});
    write_reg(REG_MID_OFFSET, {4'd0, mo});
    write_reg(REG_LOW_KNEE, {4'd0, lk});
    write_reg(REG_STEP_TICKS, st);
    write_reg(REG_FULL_HOLD_TICKS, fh);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_cfg.full_threshold = ft;
    cur_cfg.upper_knee = uk;
    cur_cfg.mid_knee = mk;
    cur_cfg.mid_offset = mo;
    cur_cfg.low_knee = lk;
    cur_cfg.step_ticks = st;
    cur_cfg.full_hold_ticks = fh;
  endtask

  // Mostly an ordered curve so every segment is reachable, sometimes knees in any order.
  task automatic random_config();
    int lk, mk, mo, uk, ft;
    logic [TICK_W-1:0] st, fh;
    if ($urandom_range(0, 9) < 7) begin
      lk = $urandom_range(0, 2500);
      mk = lk + $urandom_range(0, 400);
      mo = mk + $urandom_range(0, 40) - 20;
      uk = mk + $urandom_range(0, 400);
      ft = uk + $urandom_range(0, 200);
    end else begin
      lk = $urandom_range(0, 4095);
      mk = $urandom_range(0, 4095);
      mo = $urandom_range(0, 4095);
      uk = $urandom_range(0, 4095);
      ft = $urandom_range(0, 4095);
    end
    st = ($urandom_range(0, 4) == 0) ? TICK_W'($urandom_range(1, 65535))
                                     : TICK_W'($urandom_range(1, 6));
    fh = ($urandom_range(0, 4) == 0) ? TICK_W'($urandom_range(1, 65535))
                                     : TICK_W'($urandom_range(1, 30));
    program_gauge(clamp_code(ft), clamp_code(uk), clamp_code(mk), clamp_code(mo),
                  clamp_code(lk), st, fh);
  endtask

  // Mostly steady runs of nearly equal codes near a knee, so the display timers get to
  // expire; the rest are isolated random words.
  task automatic run_phase(input int n_words, input bit with_hold);
    int sent, run_len, base, knee, j;
    logic chg;
    bit hold_done;
    sent = 0;
    hold_done = 1'b0;
    while (sent < n_words) begin
      if (with_hold && !hold_done && sent >= n_words / 3) begin
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) begin
        offer(CODE_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
              $urandom_range(0, 19) == 0);
        sent++;
      end else begin
        case ($urandom_range(0, 5))
          0: knee = cur_cfg.full_threshold;
          1: knee = cur_cfg.upper_knee;
          2: knee = cur_cfg.mid_knee;
          3: knee = cur_cfg.mid_offset;
          4: knee = cur_cfg.low_knee;
          default: knee = $urandom_range(0, 4095);
        endcase
        base = knee + $urandom_range(0, 120) - 60;
        run_len = $urandom_range(2, 40);
        chg = ($urandom_range(0, 2) == 0);
        for (j = 0; j < run_len && sent < n_words; j++) begin
          offer(clamp_code(base + $urandom_range(0, 6) - 3), chg, $urandom_range(0, 49) == 0);
          sent++;
        end
      end
    end
    drain();
  endtask

  initial begin : stimulus
    int ph;
    in_if.valid <= 1'b0;
    in_if.voltage_code <= '0;
    in_if.charging <= 1'b0;
    in_if.resync <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    long_hold_req = 1'b0;
    burst_left = 0;
    gap_max = 0;
    cur_cfg.full_threshold = FULL_THRESHOLD_RST;
    cur_cfg.upper_knee = UPPER_KNEE_RST;
    cur_cfg.mid_knee = MID_KNEE_RST;
    cur_cfg.mid_offset = MID_OFFSET_RST;
    cur_cfg.low_knee = LOW_KNEE_RST;
    cur_cfg.step_ticks = STEP_TICKS_RST;
    cur_cfg.full_hold_ticks = FULL_HOLD_TICKS_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset curve: each knee and the code just above it, both ends of the code range.
    send_word(12'd0, 1'b0, 1'b0);
    send_word(12'd1191, 1'b0, 1'b0);
    send_word(12'd1192, 1'b0, 1'b0);
    send_word(12'd1206, 1'b0, 1'b1);
    send_word(12'd1342, 1'b0, 1'b1);
    send_word(12'd1343, 1'b1, 1'b1);
    send_word(12'd1468, 1'b0, 1'b1);
    send_word(12'd1469, 1'b0, 1'b1);
    send_word(12'd1548, 1'b0, 1'b1);
    send_word(12'd1549, 1'b0, 1'b0);
    send_word(12'd4095, 1'b1, 1'b0);
    send_word(12'd2000, 1'b0, 1'b1);
    drain();

    // Zero step and hold limits, upper overflow, middle underflow and both saturations.
    program_gauge(12'd4094, 12'd3000, 12'd2000, 12'd2600, 12'd0, 16'd0, 16'd0);
    send_word(12'd4095, 1'b0, 1'b0);
    send_word(12'd4095, 1'b0, 1'b0);
    send_word(12'd4094, 1'b0, 1'b0);
    send_word(12'd3001, 1'b1, 1'b0);
    send_word(12'd2900, 1'b0, 1'b0);
    send_word(12'd2100, 1'b0, 1'b0);
    send_word(12'd1800, 1'b0, 1'b1);
    send_word(12'd15, 1'b0, 1'b0);
    send_word(12'd0, 1'b0, 1'b0);
    send_word(12'd0, 1'b1, 1'b1);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      if (ph == 2) write_reg(REG_UNUSED_IDX, CFG_DATA_W'($urandom_range(0, 65535)));
      random_config();
      gap_max = (ph == 1) ? 0 : 6;
      run_phase(260, ph == 1 || ph == 4);
    end

    gap_max = 6;
    program_gauge(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF);
    run_phase(100, 1'b0);
    program_gauge(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'd0, 16'd0);
    run_phase(100, 1'b0);

    if (mismatches == 0 && words_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ battery_level_gauge.f @@
+incdir+sv
sv/blg_pkg.sv
sv/blg_if.sv
sv/blg_curve.sv
sv/battery_level_gauge.sv
tb/battery_level_gauge_checker.sv
tb/battery_level_gauge_tb.sv
